// ===== hdl/frqs_pkg.sv =====
// Package for the FASTQ read quality statistics block.
// Holds base classes, operation and result codes, and size constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package frqs_pkg;

    localparam int MAX_POSITIONS_DEF = 1024;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int OUT_COUNT_W       = 32;
    localparam int SUM_W             = 40;
    localparam int NUM_CLASSES       = 6;
    localparam int POS_IN_W          = 10;

    localparam logic OP_BASE    = 1'b0;
    localparam logic OP_READOUT = 1'b1;
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    localparam logic [7:0] CASE_MASK = 8'hDF;
    localparam logic [7:0] Q_MIN     = 8'h21;
    localparam logic [7:0] Q_MAX     = 8'h7E;
    localparam logic [7:0] Q20_CHAR  = 8'h35;
    localparam logic [7:0] Q30_CHAR  = 8'h3F;
    localparam logic [7:0] Q40_CHAR  = 8'h49;

    typedef enum logic [2:0] {
        CLS_A     = 3'd0,
        CLS_C     = 3'd1,
        CLS_G     = 3'd2,
        CLS_T     = 3'd3,
        CLS_N     = 3'd4,
        CLS_OTHER = 3'd5
    } base_class_t;

    function automatic base_class_t classify(input logic [7:0] ch);
        logic [7:0] b;
        b = ch & CASE_MASK;
        case (b)
            8'h41:   classify = CLS_A;
            8'h43:   classify = CLS_C;
            8'h47:   classify = CLS_G;
            8'h54:   classify = CLS_T;
            8'h4E:   classify = CLS_N;
            default: classify = CLS_OTHER;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== hdl/fastq_read_quality_stats.sv =====
// Requests pass stage 1, stage 2 and the output register; one per cycle unless m_ready stalls.
// The position table lives in one RAM (read, modify, write back) with forwarding
// from the update written back in the same cycle as the read; the read counters sit in flops.
// Reset: synchronous, active low; after reset a clearing pass walks the table,
// one entry per cycle through all MAX_POSITIONS entries, while s_ready stays low.
// Uses frqs_pkg and frqs_ram.
`timescale 1ns / 1ps
`default_nettype none
module fastq_read_quality_stats #(
    parameter int MAX_POSITIONS = frqs_pkg::MAX_POSITIONS_DEF,
    parameter int COUNT_WIDTH   = frqs_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_base_char,
    input  wire logic [7:0]  s_quality_char,
    input  wire logic        s_last_of_read,
    input  wire logic [9:0]  s_table_position,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [31:0]      m_count_a,
    output logic [31:0]      m_count_c,
    output logic [31:0]      m_count_g,
    output logic [31:0]      m_count_t,
    output logic [31:0]      m_count_n,
    output logic [31:0]      m_count_other,
    output logic [39:0]      m_quality_total,
    output logic [39:0]      m_extra_first,
    output logic [39:0]      m_extra_second,
    output logic [39:0]      m_extra_third,
    output logic [39:0]      m_extra_fourth
);
    localparam int CW    = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
    localparam int SW    = frqs_pkg::SUM_W;
    localparam int AW    = $clog2(MAX_POSITIONS);
    localparam int PW    = AW + 1;
    localparam int NC    = frqs_pkg::NUM_CLASSES;
    localparam int EW    = NC * CW + 5 * SW;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    localparam logic [SW-1:0] SMAX = {SW{1'b1}};
    localparam logic [PW-1:0] PMAX = PW'(MAX_POSITIONS);

    typedef struct packed {
        logic [NC-1:0][CW-1:0] cnt;
        logic [4:0][SW-1:0]    sum;
    } entry_t;

    function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] a);
        inc_sat = (a == CMAX) ? a : a + CW'(1);
    endfunction

    function automatic logic [SW-1:0] add_sat(input logic [SW-1:0] a,
                                               input logic [6:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + (SW+1)'(b);
        add_sat = s[SW] ? SMAX : s[SW-1:0];
    endfunction

    // clearing pass
    logic          clr_busy_reg;
    logic [AW:0]   clr_addr_reg;

    // output stage (skid via ready-when-empty-or-taken)
    logic          out_v_reg;
    logic          adv;
    assign adv = !out_v_reg || m_ready;

    // stage 1: accepted request
    logic          s1_v_reg, s1_op_reg, s1_upd_reg, s1_emit_reg, s1_inrange_reg;
    logic [AW-1:0] s1_addr_reg;
    frqs_pkg::base_class_t s1_cls_reg;
    logic [6:0]    s1_phred_reg;
    logic [EW-1:0] s1_read_snap_reg;

    // stage 2: RAM data valid, modify
    logic          s2_v_reg, s2_op_reg, s2_upd_reg, s2_emit_reg, s2_inrange_reg;
    logic [AW-1:0] s2_addr_reg;
    frqs_pkg::base_class_t s2_cls_reg;
    logic [6:0]    s2_phred_reg;
    logic [EW-1:0] s2_read_snap_reg;

    assign s_ready = aresetn && !clr_busy_reg && adv;
    logic acc;
    assign acc = s_valid && s_ready;

    // read state
    logic [PW-1:0]         rpos_reg;
    logic                  rinv_reg;
    logic [2:0][CW-1:0]    rthr_reg;
    logic [NC-1:0][CW-1:0] rcls_reg;
    logic [SW-1:0]         rsum_reg;

    logic       q_ok, upd;
    logic [6:0] phred;
    frqs_pkg::base_class_t cls;
    assign q_ok  = (s_quality_char >= frqs_pkg::Q_MIN) && (s_quality_char <= frqs_pkg::Q_MAX);
    assign phred = 7'(s_quality_char - frqs_pkg::Q_MIN);
    assign cls   = frqs_pkg::classify(s_base_char);
    assign upd   = (s_operation == frqs_pkg::OP_BASE) && !rinv_reg && q_ok;

    // next read state after this base
    logic [2:0][CW-1:0]    rthr_n;
    logic [NC-1:0][CW-1:0] rcls_n;
    logic [SW-1:0]         rsum_n;
    logic                  rinv_n;
    always_comb begin
        rthr_n = rthr_reg;
        rcls_n = rcls_reg;
        rsum_n = rsum_reg;
        rinv_n = rinv_reg || !q_ok;
        if (upd) begin
            if (s_quality_char >= frqs_pkg::Q20_CHAR) rthr_n[0] = inc_sat(rthr_reg[0]);
            if (s_quality_char >= frqs_pkg::Q30_CHAR) rthr_n[1] = inc_sat(rthr_reg[1]);
            if (s_quality_char >= frqs_pkg::Q40_CHAR) rthr_n[2] = inc_sat(rthr_reg[2]);
            rsum_n = add_sat(rsum_reg, phred);
            rcls_n[cls] = inc_sat(rcls_reg[cls]);
        end
    end

    // read counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpos_reg <= '0;
            rinv_reg <= 1'b0;
            rthr_reg <= '0;
            rcls_reg <= '0;
            rsum_reg <= '0;
        end else if (acc && s_operation == frqs_pkg::OP_BASE) begin
            if (s_last_of_read) begin
                rpos_reg <= '0;
                rinv_reg <= 1'b0;
                rthr_reg <= '0;
                rcls_reg <= '0;
                rsum_reg <= '0;
            end else begin
                rinv_reg <= rinv_n;
                rthr_reg <= rthr_n;
                rcls_reg <= rcls_n;
                rsum_reg <= rsum_n;
                if (upd && rpos_reg < PMAX) rpos_reg <= rpos_reg + PW'(1);
            end
        end
    end

    // read summary snapshot: class counts, sum, Q20, Q30, Q40, invalid flag
    logic [EW-1:0] read_snap;
    assign read_snap = {rcls_n, rsum_n, SW'(rthr_n[0]), SW'(rthr_n[1]), SW'(rthr_n[2]),
                        SW'(rinv_n)};

    // table address for a request
    logic [AW-1:0] req_addr;
    logic          req_inrange;
    always_comb begin
        if (s_operation == frqs_pkg::OP_READOUT) begin
            req_inrange = 32'(s_table_position) < MAX_POSITIONS;
            req_addr    = AW'(s_table_position);
        end else begin
            req_inrange = rpos_reg < PMAX;
            req_addr    = AW'(rpos_reg);
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_v_reg <= acc;
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg        <= s_operation;
            s1_upd_reg       <= upd && req_inrange;
            s1_emit_reg      <= (s_operation == frqs_pkg::OP_READOUT) || s_last_of_read;
            s1_inrange_reg   <= req_inrange;
            s1_addr_reg      <= req_addr;
            s1_cls_reg       <= cls;
            s1_phred_reg     <= phred;
            s1_read_snap_reg <= read_snap;
            s2_op_reg        <= s1_op_reg;
            s2_upd_reg       <= s1_upd_reg;
            s2_emit_reg      <= s1_emit_reg;
            s2_inrange_reg   <= s1_inrange_reg;
            s2_addr_reg      <= s1_addr_reg;
            s2_cls_reg       <= s1_cls_reg;
            s2_phred_reg     <= s1_phred_reg;
            s2_read_snap_reg <= s1_read_snap_reg;
        end
    end

    // RAM: read at stage 1 address, write back from stage 2
    logic [EW-1:0] ram_rd;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        mod_entry, cur_entry;
    assign ram_raddr = adv ? s1_addr_reg : s2_addr_reg;
    assign ram_we    = clr_busy_reg || (adv && s2_v_reg && s2_upd_reg);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg[AW-1:0] : s2_addr_reg;

    frqs_ram #(.WIDTH(EW), .DEPTH(MAX_POSITIONS)) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (clr_busy_reg ? EW'(0) : EW'(mod_entry)),
        .rd_addr (ram_raddr),
        .rd_data (ram_rd)
    );

    // forwarding: a write in the same cycle as the read misses the RAM data
    logic   fwd_v_reg;
    entry_t fwd_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_v_reg <= 1'b0;
        end else begin
            fwd_v_reg <= ram_we && !clr_busy_reg && (ram_waddr == ram_raddr);
        end
        fwd_data_reg <= mod_entry;
    end

    always_comb begin
        cur_entry = entry_t'(ram_rd);
        if (fwd_v_reg) cur_entry = fwd_data_reg;
    end

    always_comb begin
        mod_entry = cur_entry;
        mod_entry.cnt[s2_cls_reg] = inc_sat(cur_entry.cnt[s2_cls_reg]);
        mod_entry.sum[0] = add_sat(cur_entry.sum[0], s2_phred_reg);
        if (s2_cls_reg <= frqs_pkg::CLS_T) begin
            mod_entry.sum[1 + int'(s2_cls_reg)] =
                add_sat(cur_entry.sum[1 + int'(s2_cls_reg)], s2_phred_reg);
        end
    end

    // clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + (AW+1)'(1);
            if (clr_addr_reg == (AW+1)'(MAX_POSITIONS - 1)) clr_busy_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= s2_v_reg && s2_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_result_kind <= s2_op_reg;
            if (s2_op_reg == frqs_pkg::OP_READOUT) begin
                if (s2_inrange_reg) begin
                    m_count_a       <= 32'(cur_entry.cnt[0]);
                    m_count_c       <= 32'(cur_entry.cnt[1]);
                    m_count_g       <= 32'(cur_entry.cnt[2]);
                    m_count_t       <= 32'(cur_entry.cnt[3]);
                    m_count_n       <= 32'(cur_entry.cnt[4]);
                    m_count_other   <= 32'(cur_entry.cnt[5]);
                    m_quality_total <= cur_entry.sum[0];
                    m_extra_first   <= cur_entry.sum[1];
                    m_extra_second  <= cur_entry.sum[2];
                    m_extra_third   <= cur_entry.sum[3];
                    m_extra_fourth  <= cur_entry.sum[4];
                end else begin
                    {m_count_a, m_count_c, m_count_g, m_count_t, m_count_n,
                     m_count_other} <= '0;
                    {m_quality_total, m_extra_first, m_extra_second,
                     m_extra_third, m_extra_fourth} <= '0;
                end
            end else begin
                m_count_a       <= 32'(s2_read_snap_reg[5*SW +: CW]);
                m_count_c       <= 32'(s2_read_snap_reg[5*SW + CW +: CW]);
                m_count_g       <= 32'(s2_read_snap_reg[5*SW + 2*CW +: CW]);
                m_count_t       <= 32'(s2_read_snap_reg[5*SW + 3*CW +: CW]);
                m_count_n       <= 32'(s2_read_snap_reg[5*SW + 4*CW +: CW]);
                m_count_other   <= 32'(s2_read_snap_reg[5*SW + 5*CW +: CW]);
                m_quality_total <= s2_read_snap_reg[4*SW +: SW];
                m_extra_first   <= s2_read_snap_reg[3*SW +: SW];
                m_extra_second  <= s2_read_snap_reg[2*SW +: SW];
                m_extra_third   <= s2_read_snap_reg[SW +: SW];
                m_extra_fourth  <= s2_read_snap_reg[0 +: SW];
            end
        end
    end
    assign m_valid = out_v_reg;

`ifndef SYNTHESIS
    // a result waiting for m_ready keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_result_kind, m_count_a, m_count_c,
            m_count_g, m_count_t, m_count_n, m_count_other, m_quality_total,
            m_extra_first, m_extra_second, m_extra_third, m_extra_fourth}));
    // no request taken while the table is being cleared
    a_clear_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready);
    // pipeline stays empty during the clearing pass
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s1_v_reg && !s2_v_reg && !out_v_reg);
    // read position stops at the table size
    a_rpos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rpos_reg <= PMAX);
`endif

endmodule
`default_nettype wire

// ===== hdl/frqs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module frqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire
